FILE: hdl/tlsr_pkg.sv
`default_nettype none
package tlsr_pkg;
	localparam int ParentNodes = 32;
	localparam int ChildNodes = 64;
	localparam int CntMax = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_ROUTE = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  node_index;
		logic        node_is_leaf;
		logic [9:0]  node_variable;
		logic signed [31:0] node_threshold;
		logic [5:0]  left_index;
		logic [5:0]  right_index;
		logic [5:0]  sample_status;
		logic signed [31:0] feature_value;
		logic [31:0] sample_weight;
		logic signed [31:0] sample_target;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [6:0]  new_status;
		logic [9:0]  lookup_variable;
		logic        lookup_is_leaf;
		logic [5:0]  child_index;
		logic [23:0] child_sample_count;
		logic [47:0] child_weight_sum;
		logic signed [63:0] child_weighted_target_sum;
		logic signed [31:0] child_mean;
		logic        last_result;
	} out_item_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic [1:0]  kind;
		logic        drop;
		logic [5:0]  child;
		logic [9:0]  variable;
		logic        leaf;
		logic [31:0] weight;
		logic signed [31:0] target;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_MUL, BK_ACC, BK_FRD, BK_FDIV, BK_FOUT
	} bk_state_t;
endpackage
`default_nettype wire

FILE: hdl/tlsr_ram.sv
`default_nettype none
module tlsr_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/tlsr_front.sv
`default_nettype none
// Front part: writes and reads the node table and classifies each item.
module tlsr_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire tlsr_pkg::in_item_t in_item,
	output logic in_stall,
	output logic q_push,
	output tlsr_pkg::cmd_t q_data,
	input  wire logic q_full
);
	logic [54:0] rd;
	logic busy_q;
	tlsr_pkg::in_item_t it_s1;
	logic tbl_we, valid_st;
	logic [9:0] var_c;
	logic [4:0] tbl_raddr;
	logic signed [31:0] thr;
	logic [5:0] lft, rgt, ch;

	assign in_stall = busy_q;
	assign tbl_we = in_valid && !busy_q
		&& in_item.operation == tlsr_pkg::OP_LOAD;
	assign var_c = in_item.node_variable;
	// While an item waits for room in the queue the table keeps reading its
	// entry, so the read data stays valid until the item is pushed.
	assign tbl_raddr = busy_q ? 5'(it_s1.sample_status - 6'd1)
		: 5'(in_item.sample_status - 6'd1);

	tlsr_ram #(.Width(55), .Depth(tlsr_pkg::ParentNodes)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(in_item.node_index),
		.wdata({in_item.node_is_leaf, var_c, in_item.node_threshold,
			in_item.left_index, in_item.right_index}),
		.raddr(tbl_raddr), .rdata(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			busy_q <= in_valid;
		end else if (!q_full) begin
			busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			it_s1 <= in_item;
		end
	end

	assign valid_st = it_s1.sample_status != 6'd0 && it_s1.sample_status <= 6'd32;
	assign thr = rd[43:12];
	assign lft = rd[11:6];
	assign rgt = rd[5:0];
	assign ch = (it_s1.feature_value < thr) ? lft : rgt;

	always_comb begin
		q_push = busy_q && !q_full;
		q_data.kind = it_s1.operation;
		q_data.leaf = !valid_st || rd[54];
		q_data.variable = valid_st ? rd[53:44] : 10'd0;
		q_data.drop = !valid_st || rd[54];
		q_data.child = ch;
		q_data.weight = it_s1.sample_weight;
		q_data.target = it_s1.sample_target;
	end
endmodule
`default_nettype wire

FILE: hdl/tlsr_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle, 64 by 48 bits, magnitude only.
// Done stays high from the end of a division until the next start.
module tlsr_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [63:0] num,
	input  wire logic [47:0] den,
	output logic done,
	output logic [63:0] quo
);
	logic [6:0] cnt_q;
	logic [48:0] rem_q;
	logic [63:0] q_q;
	logic [48:0] sh;
	logic busy_q;
	assign sh = {rem_q[47:0], q_q[63]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 7'd0;
			done <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
				done <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= num;
		end else if (busy_q) begin
			if (sh >= {1'b0, den}) begin
				rem_q <= sh - {1'b0, den};
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

FILE: hdl/tlsr_back.sv
`default_nettype none
// Back part: accumulates routed samples and walks the children on finish.
module tlsr_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [6:0] child_node_count,
	input  wire logic q_valid,
	input  wire tlsr_pkg::cmd_t q_data,
	output logic q_pop,
	output logic out_valid,
	output tlsr_pkg::out_item_t out_item,
	input  wire logic out_stall
);
	tlsr_pkg::bk_state_t st_q, st_d;
	tlsr_pkg::cmd_t c_q;
	logic [63:0] valid_q;
	logic [5:0] idx_q, raddr;
	logic [6:0] n_q;
	logic [135:0] rdat, wdat;
	logic we;
	logic [5:0] waddr;
	logic signed [63:0] prod_q, ts, tsum;
	logic [23:0] cnt, cnt_n;
	logic [47:0] ws, ws_n;
	logic [48:0] wsum;
	logic [64:0] tsx;
	logic div_start, div_done;
	logic [63:0] mag, quo;
	logic signed [31:0] mean;
	logic out_load;
	tlsr_pkg::out_item_t o_d;

	tlsr_ram #(.Width(136), .Depth(tlsr_pkg::ChildNodes)) u_acc (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdat), .raddr(raddr), .rdata(rdat)
	);
	tlsr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mag), .den(ws),
		.done(div_done), .quo(quo)
	);

	assign cnt = valid_q[idx_q] ? rdat[135:112] : 24'd0;
	assign ws = valid_q[idx_q] ? rdat[111:64] : 48'd0;
	assign ts = valid_q[idx_q] ? $signed(rdat[63:0]) : 64'sd0;
	assign cnt_n = (cnt == 24'(tlsr_pkg::CntMax)) ? cnt : cnt + 24'd1;
	assign wsum = {1'b0, ws} + {17'd0, c_q.weight};
	assign ws_n = wsum[48] ? 48'hFFFFFFFFFFFF : wsum[47:0];
	assign tsx = {ts[63], ts} + {prod_q[63], prod_q};
	assign tsum = (tsx[64] != tsx[63]) ? (tsx[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
		: tsx[63:0];
	assign mag = ts[63] ? 64'(-ts) : ts;
	always_comb begin
		if (ws == 48'd0) begin
			mean = 32'sd0;
		end else if (ts[63]) begin
			mean = (quo >= 64'h80000000) ? 32'sh80000000 : 32'(-$signed(quo[31:0]));
		end else begin
			mean = (quo > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo[31:0]);
		end
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		we = 1'b0;
		waddr = idx_q;
		wdat = {cnt_n, ws_n, tsum};
		raddr = idx_q;
		div_start = 1'b0;
		out_load = 1'b0;
		o_d = '0;
		o_d.result_kind = c_q.kind;
		o_d.last_result = 1'b1;
		case (st_q)
			tlsr_pkg::BK_IDLE: begin
				// A finish item starts its walk at child 0.
				raddr = (q_data.kind == 2'(tlsr_pkg::OP_FINISH)) ? 6'd0 : q_data.child;
				if (q_valid && !out_valid) begin
					q_pop = 1'b1;
					case (tlsr_pkg::op_t'(q_data.kind))
						tlsr_pkg::OP_ROUTE: st_d = q_data.drop ? tlsr_pkg::BK_FOUT
							: tlsr_pkg::BK_MUL;
						tlsr_pkg::OP_FINISH: st_d = tlsr_pkg::BK_FRD;
						default: st_d = tlsr_pkg::BK_FOUT;
					endcase
				end
			end
			tlsr_pkg::BK_MUL: st_d = tlsr_pkg::BK_ACC;
			tlsr_pkg::BK_ACC: begin
				we = 1'b1;
				st_d = tlsr_pkg::BK_FOUT;
			end
			tlsr_pkg::BK_FRD: begin
				if (n_q == 7'd0) begin
					st_d = tlsr_pkg::BK_IDLE;
				end else begin
					div_start = 1'b1;
					st_d = tlsr_pkg::BK_FDIV;
				end
			end
			tlsr_pkg::BK_FDIV: begin
				if (div_done && !out_valid) begin
					out_load = 1'b1;
					o_d.child_index = idx_q;
					o_d.child_sample_count = cnt;
					o_d.child_weight_sum = ws;
					o_d.child_weighted_target_sum = ts;
					o_d.child_mean = mean;
					o_d.last_result = (7'(idx_q) + 7'd1 == n_q);
					raddr = 6'(idx_q + 6'd1);
					st_d = o_d.last_result ? tlsr_pkg::BK_IDLE : tlsr_pkg::BK_FRD;
				end
			end
			tlsr_pkg::BK_FOUT: begin
				if (!out_valid) begin
					out_load = 1'b1;
					o_d.new_status = (c_q.kind == 2'(tlsr_pkg::OP_ROUTE) && !c_q.drop)
						? 7'(idx_q) + 7'd1 : 7'd0;
					o_d.lookup_variable = (c_q.kind == 2'(tlsr_pkg::OP_LOOKUP))
						? c_q.variable : 10'd0;
					o_d.lookup_is_leaf = (c_q.kind == 2'(tlsr_pkg::OP_LOOKUP)) && c_q.leaf;
					st_d = tlsr_pkg::BK_IDLE;
				end
			end
			default: st_d = tlsr_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tlsr_pkg::BK_IDLE;
			out_valid <= 1'b0;
			valid_q <= '0;
			idx_q <= '0;
		end else begin
			st_q <= st_d;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			if (we) valid_q[idx_q] <= 1'b1;
			if (q_pop) idx_q <= (q_data.kind == 2'(tlsr_pkg::OP_FINISH)) ? 6'd0 : q_data.child;
			if (st_q == tlsr_pkg::BK_FDIV && out_load) begin
				idx_q <= 6'(idx_q + 6'd1);
				if (o_d.last_result) valid_q <= '0;
			end
			if (st_q == tlsr_pkg::BK_FRD && n_q == 7'd0) valid_q <= '0;
		end
	end
	always_ff @(posedge clk) begin
		if (q_pop) begin
			c_q <= q_data;
			n_q <= (child_node_count > 7'd64) ? 7'd64 : child_node_count;
		end
		if (st_q == tlsr_pkg::BK_MUL) prod_q <= $signed({1'b0, c_q.weight}) * c_q.target;
		if (out_load) out_item <= o_d;
	end
endmodule
`default_nettype wire

FILE: hdl/tree_layer_sample_router.sv
`default_nettype none
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | tlsr_pkg::in_item_t
// out     | output    | valid / stall | tlsr_pkg::out_item_t
// cfg     | input     | valid / ready | child_node_count (7 bits)
//
// Load and lookup pass through the table read; a route that is not dropped
// also passes the registered multiply and the accumulator read-modify-write.
// Finish walks the children in turn through the bit-serial mean divider.
// Reset clears all control state and the accumulator valid bits at once.
// Either side may stall; a two-entry queue sits between front and back.
module tree_layer_sample_router (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire tlsr_pkg::in_item_t in_item,
	output logic out_valid,
	input  wire logic out_stall,
	output tlsr_pkg::out_item_t out_item,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [6:0] cfg_data
);
	logic [6:0] cnt_q;
	logic q_push, q_pop, q_full;
	tlsr_pkg::cmd_t q_in;
	tlsr_pkg::cmd_t q_mem [2];
	logic [1:0] q_cnt_q;
	logic q_rd_q, q_wr_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// The front part presents classified items; the queue holds two of them.
	tlsr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_item(in_item),
		.in_stall(in_stall), .q_push(q_push), .q_data(q_in), .q_full(q_full)
	);

	assign q_full = q_cnt_q == 2'd2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= 2'd0;
			q_rd_q <= 1'b0;
			q_wr_q <= 1'b0;
		end else begin
			q_cnt_q <= q_cnt_q + 2'(q_push) - 2'(q_pop);
			if (q_push) q_wr_q <= !q_wr_q;
			if (q_pop) q_rd_q <= !q_rd_q;
		end
	end
	always_ff @(posedge clk) begin
		if (q_push) q_mem[q_wr_q] <= q_in;
	end

	tlsr_back u_back (
		.clk(clk), .arst_n(arst_n), .child_node_count(cnt_q),
		.q_valid(q_cnt_q != 2'd0), .q_data(q_mem[q_rd_q]), .q_pop(q_pop),
		.out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
	);

`ifndef ASSERT_OFF
	a_q_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("queue overflow");
	a_q_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		(q_cnt_q == 2'd0) |-> !q_pop) else $error("queue underflow");
	a_q_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q != 2'd3) else $error("queue count invalid");
`endif
endmodule
`default_nettype wire
